// ----- sv/assert_macros.svh -----
// Assertion helpers for the checker file, esg_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ESG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked implication, disabled while reset is asserted.
`define ESG_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- sv/esg_pkg.sv -----
`default_nettype none
package esg_pkg;

	localparam int SINE_ADDR_BITS = 10;
	localparam int COUNT_BITS     = 16;
	localparam int PHASE_BITS     = 32;
	localparam int ROM_SIZE       = 1 << SINE_ADDR_BITS;
	localparam int QUARTER        = ROM_SIZE >> 2;
	localparam int S_DATA_W       = 48;
	localparam int M_DATA_W       = 16;
	localparam int DIV_STEPS      = PHASE_BITS;
	localparam int DIV_CNT_BITS   = $clog2(DIV_STEPS);

	typedef logic signed [15:0]          sine_t;
	typedef logic [PHASE_BITS-1:0]       phase_t;
	typedef logic [COUNT_BITS-1:0]       count_t;
	typedef logic [SINE_ADDR_BITS-1:0]   rom_addr_t;
	typedef sine_t                       rom_t [ROM_SIZE];

	localparam logic [15:0] GAIN_RESET = 16'd11469;
	localparam phase_t      ENV_FULL   = phase_t'(64'h8000_0000);
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// (2k)(2k+1) for the Taylor terms k = 1..7
	localparam logic [63:0] TAYLOR_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
		64'd110, 64'd156, 64'd210};

	// round(32767 * sin(pi/2 * q / QUARTER)), Q30 Taylor series
	function automatic sine_t quarter_sine(input int unsigned q);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] v;
		x = (HALF_PI_Q30 * 64'(q)) / QUARTER;
		x2 = (x * x) >> 30;
		term = x;
		sum = x;
		for (int k = 1; k <= 7; k++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[k];
			if (k % 2 == 1) begin
				sum = (sum > term) ? sum - term : 64'd0;
			end else begin
				sum = sum + term;
			end
		end
		v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return sine_t'(v);
	endfunction

	function automatic rom_t build_rom();
		rom_t rom;
		int unsigned quad;
		int unsigned r;
		for (int unsigned i = 0; i < ROM_SIZE; i++) begin
			quad = i / QUARTER;
			r = i % QUARTER;
			unique case (quad)
				0: rom[i] = quarter_sine(r);
				1: rom[i] = quarter_sine(QUARTER - r);
				2: rom[i] = -quarter_sine(r);
				default: rom[i] = -quarter_sine(QUARTER - r);
			endcase
		end
		return rom;
	endfunction

endpackage
`default_nettype wire

// ----- sv/enveloped_sine_tone_generator.sv -----
// Note tone generator: a DDS sine oscillator shaped by a half-sine envelope.
// Input beats carry tuser = 1 for "start note" (tdata: tone_step in bits
// 31:0, note_samples in bits 47:32) and tuser = 0 for a sample tick. A start
// gives no output beat; it clears both phase accumulators, holds the tone
// step and works out the envelope step 2^31 / note_samples on a restoring
// divider, one quotient bit per cycle; a start holds off further beats while
// it takes the beat, runs the 32 divider steps and picks up the result;
// a start with a zero count ends any note and leaves the block idle. Each tick
// gives exactly one output beat: tdata = sample, tuser = active, tlast = last
// sample of the note. A tick runs through its steps (beat, tone ROM read, envelope
// ROM read and first multiply, gain multiply, saturate) set by the single
// sine ROM port and the one shared 17x17 multiplier; a tick with no note
// sounding goes straight to the saturate step. A tick waits at the end only
// while an earlier beat is still held in the output register. Ticks with no
// note sounding give sample 0. The gain register (APB, address 0, Q1.15,
// reset 0.35) may be written only while the block is idle.
`default_nettype none
module enveloped_sine_tone_generator import esg_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// slave stream
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [S_DATA_W-1:0] s_tdata,   // [31:0] tone_step, [47:32] note_samples
	input  wire logic                s_tuser,   // req_type
	// master stream
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [M_DATA_W-1:0]      m_tdata,   // [15:0] sample
	output logic                     m_tuser,   // active
	output logic                     m_tlast,   // last_sample
	// APB config
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [2:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);

	localparam logic REG_GAIN = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_ROM_T,
		ST_ROM_E,
		ST_MUL2,
		ST_SAT
	} state_t;

	// ---------------- config ----------------
	logic [15:0] gain_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_GAIN) begin
			gain_q <= pwdata[15:0];
		end
	end

	assign prdata = (paddr[2] == REG_GAIN) ? {16'd0, gain_q} : 32'd0;

	// ---------------- sequencer state ----------------
	state_t       state_q;
	phase_t       tone_phase_q;
	phase_t       env_phase_q;
	phase_t       env_step_q;
	phase_t       step_held_q;
	count_t       samples_left_q;
	logic         playing_q;
	logic         zero_q;       // idle tick: result forced to zero
	sine_t        tone_q;
	logic signed [33:0] prod_q;
	logic         m_tvalid_q;
	sine_t        m_sample_q;
	logic         m_active_q;
	logic         m_last_q;

	// input beat fields
	logic   s_fire;
	phase_t tone_step_w;
	count_t count_w;

	assign s_tready    = (state_q == ST_IDLE);
	assign s_fire      = s_tvalid && s_tready;
	assign tone_step_w = s_tdata[31:0];
	assign count_w     = count_t'(s_tdata[47:32]);

	// ---------------- sine ROM, shared by tone and envelope ----------------
	rom_addr_t rom_addr;
	sine_t     rom_data;

	// tone address goes out on the accepting edge, envelope address in the cycle after, from ROM_T
	assign rom_addr = (state_q == ST_IDLE) ? tone_phase_q[PHASE_BITS-1 -: SINE_ADDR_BITS]
	                                       : env_phase_q[PHASE_BITS-1 -: SINE_ADDR_BITS];

	esg_sine_rom u_rom (
		.clk  (clk),
		.addr (rom_addr),
		.data (rom_data)
	);

	// ---------------- envelope step divider ----------------
	logic   div_start;
	logic   div_done;
	phase_t div_quo;

	assign div_start = s_fire && s_tuser && (count_w != '0);

	esg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (count_w),
		.done     (div_done),
		.quotient (div_quo)
	);

	// ---------------- shared multiplier ----------------
	// ROM_E: tone * envelope; MUL2: (product >>> 15) * gain
	logic signed [33:0] prod_shift;
	logic signed [16:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [33:0] mul_p;

	assign prod_shift = prod_q >>> 15;
	assign mul_a = (state_q == ST_ROM_E) ? 17'(tone_q) : prod_shift[16:0];
	assign mul_b = (state_q == ST_ROM_E) ? 17'(rom_data) : $signed({1'b0, gain_q});
	assign mul_p = mul_a * mul_b;

	// ---------------- saturation ----------------
	logic signed [18:0] v_w;
	sine_t              sat_w;
	logic               out_free;

	assign v_w = prod_q[33:15];

	always_comb begin
		priority if (v_w > 19'sd32767) begin
			sat_w = 16'sd32767;
		end else if (v_w < -19'sd32767) begin
			sat_w = -16'sd32767;
		end else begin
			sat_w = v_w[15:0];
		end
	end

	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			tone_phase_q   <= '0;
			env_phase_q    <= '0;
			env_step_q     <= '0;
			step_held_q    <= '0;
			samples_left_q <= '0;
			playing_q      <= 1'b0;
			zero_q         <= 1'b0;
			tone_q         <= '0;
			prod_q         <= '0;
			m_tvalid_q     <= 1'b0;
			m_sample_q     <= '0;
			m_active_q     <= 1'b0;
			m_last_q       <= 1'b0;
		end else begin
			// drained beat, unless the saturate step loads the next one
			if (m_tvalid_q && m_tready && !(state_q == ST_SAT)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						if (s_tuser) begin
							tone_phase_q   <= '0;
							env_phase_q    <= '0;
							step_held_q    <= tone_step_w;
							samples_left_q <= count_w;
							if (count_w != '0) begin
								playing_q <= 1'b1;
								state_q   <= ST_DIV;
							end else begin
								env_step_q <= '0;
								playing_q  <= 1'b0;
							end
						end else if (playing_q) begin
							zero_q  <= 1'b0;
							state_q <= ST_ROM_T;
						end else begin
							zero_q  <= 1'b1;
							state_q <= ST_SAT;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						env_step_q <= div_quo;
						state_q    <= ST_IDLE;
					end
				end
				ST_ROM_T: begin
					tone_q  <= rom_data;
					state_q <= ST_ROM_E;
				end
				ST_ROM_E: begin
					prod_q  <= mul_p;
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					prod_q  <= mul_p;
					state_q <= ST_SAT;
				end
				ST_SAT: begin
					// out_free holds whenever the held beat drains this cycle
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						if (zero_q) begin
							m_sample_q <= '0;
							m_active_q <= 1'b0;
							m_last_q   <= 1'b0;
						end else begin
							m_sample_q     <= sat_w;
							m_active_q     <= 1'b1;
							m_last_q       <= (samples_left_q == count_t'(1));
							tone_phase_q   <= tone_phase_q + step_held_q;
							env_phase_q    <= env_phase_q + env_step_q;
							samples_left_q <= samples_left_q - 1'b1;
							if (samples_left_q == count_t'(1)) begin
								playing_q <= 1'b0;
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_sample_q;
	assign m_tuser  = m_active_q;
	assign m_tlast  = m_last_q;

endmodule
`default_nettype wire

// ----- sv/esg_sine_rom.sv -----
`default_nettype none
module esg_sine_rom import esg_pkg::*; (
	input  wire logic      clk,
	input  wire rom_addr_t addr,
	output sine_t          data
);

	localparam rom_t SINE_ROM = build_rom();

	sine_t data_q;

	// synchronous read, one port
	always_ff @(posedge clk) begin
		data_q <= SINE_ROM[addr];
	end

	assign data = data_q;

endmodule
`default_nettype wire

// ----- sv/esg_div.sv -----
`default_nettype none
module esg_div import esg_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   start,
	input  wire count_t divisor,
	output logic        done,
	output phase_t      quotient
);

	// restoring divider: ENV_FULL / divisor, one quotient bit per cycle
	logic                      busy_q;
	logic                      done_q;
	logic [DIV_CNT_BITS-1:0]   step_q;
	count_t                    rem_q;
	count_t                    divisor_q;
	phase_t                    quo_q;
	logic [COUNT_BITS+1:0]     trial;
	logic                      ge;
	logic [COUNT_BITS:0]       shifted;

	assign shifted = {rem_q, quo_q[PHASE_BITS-1]};
	assign trial   = {1'b0, shifted} - {2'b00, divisor_q};
	assign ge      = !trial[COUNT_BITS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
			step_q    <= '0;
			rem_q     <= '0;
			divisor_q <= '0;
			quo_q     <= '0;
		end else if (start) begin
			busy_q    <= 1'b1;
			done_q    <= 1'b0;
			step_q    <= '0;
			rem_q     <= '0;
			divisor_q <= divisor;
			quo_q     <= ENV_FULL;
		end else if (busy_q) begin
			rem_q  <= ge ? trial[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
			quo_q  <= {quo_q[PHASE_BITS-2:0], ge};
			step_q <= step_q + 1'b1;
			if (step_q == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

// ----- sv/esg_checker.sv -----
`default_nettype none
`include "assert_macros.svh"
module esg_checker import esg_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                m_tvalid,
	input wire logic                m_tready,
	input wire logic [M_DATA_W-1:0] m_tdata,
	input wire logic                m_tuser,
	input wire logic                m_tlast
);

	// stalled beat holds
	`ESG_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output beat changed under stall")
	// silent beats are all zero
	`ESG_ASSERT_IMP(a_idle_zero, m_tvalid && !m_tuser, m_tdata == 16'd0 && !m_tlast, "idle beat not zero")
	// last sample only inside a note
	`ESG_ASSERT_IMP(a_last_active, m_tvalid && m_tlast, m_tuser, "tlast without active")
	// saturation keeps the sample off the negative full scale code
	`ESG_ASSERT_IMP(a_sat_range, m_tvalid, m_tdata != 16'h8000, "sample out of range")

endmodule

bind enveloped_sine_tone_generator esg_checker u_esg_checker (.*);
`default_nettype wire
